// ===== hw/rtl/mkvp_pkg.sv =====
// Shared constants, key tables and the queue item type for the meminfo parser.
package mkvp_pkg;

  localparam int NKEYS = 7;
  localparam int KEY_POS = 16;
  localparam int POS_W = 4;
  localparam int VALUE_W = 64;
  localparam int SCALE_SHIFT = 10;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_NL = 8'd10;
  localparam logic [7:0] CHAR_TAB = 8'd9;
  localparam logic [7:0] CHAR_SP = 8'd32;
  localparam logic [7:0] CHAR_ZERO = 8'd48;
  localparam logic [7:0] CHAR_NINE = 8'd57;

  // Key strings are right-justified: the last character sits in the low byte.
  localparam logic [KEY_POS*8-1:0] KEY_TEXT [NKEYS] = '{
    "MemTotal:", "MemFree:", "MemAvailable:", "Buffers:",
    "Cached:", "SwapTotal:", "SwapFree:"
  };
  localparam int KEY_LEN [NKEYS] = '{9, 8, 13, 8, 7, 10, 9};

  typedef struct packed {
    logic                            last;
    logic                            is_nl;
    logic                            is_blank;
    logic                            is_digit;
    logic [3:0]                      digit;
    logic [NKEYS-1:0][KEY_POS-1:0]   hits;
  } item_t;

endpackage

// ===== hw/rtl/mkvp_front.sv =====
// Front end: accepts bytes and classifies them against the key table.
module mkvp_front (
  input  logic [7:0]     text_byte,
  input  logic           final_byte,
  input  logic           push,
  input  logic           q_full,
  output logic           q_push,
  output mkvp_pkg::item_t q_item
);
  import mkvp_pkg::*;

  logic [7:0] digit_off;

  assign q_push = push && !q_full;
  assign digit_off = text_byte - CHAR_ZERO;

  always_comb begin
    q_item = '0;
    q_item.last = final_byte;
    q_item.is_nl = (text_byte == CHAR_NL);
    q_item.is_blank = (text_byte == CHAR_SP) || (text_byte == CHAR_TAB);
    q_item.is_digit = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
    q_item.digit = digit_off[3:0];
    // A hit at a position means the byte equals that key's character there.
    for (int k = 0; k < NKEYS; k++) begin
      for (int p = 0; p < KEY_POS; p++) begin
        if (p < KEY_LEN[k]) begin
          q_item.hits[k][p] = (text_byte == KEY_TEXT[k][(KEY_LEN[k]-1-p)*8 +: 8]);
        end
      end
    end
  end

endmodule

// ===== hw/rtl/mkvp_queue.sv =====
// Small register queue between the classifier and the parser.
module mkvp_queue #(
  parameter int Depth = mkvp_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mkvp_pkg::item_t item_in,
  output logic            full,
  input  logic            pop,
  output mkvp_pkg::item_t item_out,
  output logic            nonempty
);
  import mkvp_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  item_t         slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full = (count == CntW'(Depth));
  assign nonempty = (count != '0);
  assign item_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/mkvp_back.sv =====
// Back end: line parser, value slots and the result register.
module mkvp_back (
  input  logic                         clk,
  input  logic                         rst,
  input  mkvp_pkg::item_t              q_item,
  input  logic                         q_nonempty,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         pop,
  output logic [mkvp_pkg::VALUE_W-1:0] out_slots [mkvp_pkg::NKEYS],
  output logic                         out_status
);
  import mkvp_pkg::*;

  typedef enum logic [4:0] {
    PH_BLANK  = 5'b00001,
    PH_KEY    = 5'b00010,
    PH_GAP    = 5'b00100,
    PH_DIGITS = 5'b01000,
    PH_IGNORE = 5'b10000
  } phase_t;

  phase_t             phase;
  logic [NKEYS-1:0]   cand;
  logic [POS_W-1:0]   pos;
  logic [VALUE_W-1:0] acc;
  logic               ovf;
  logic [VALUE_W-1:0] slots [NKEYS];
  logic               any_ok;

  phase_t             phase_next;
  logic [NKEYS-1:0]   cand_next;
  logic [POS_W-1:0]   pos_next;
  logic [VALUE_W-1:0] acc_next;
  logic               ovf_next;
  logic [VALUE_W-1:0] slots_next [NKEYS];
  logic               any_ok_next;

  logic [NKEYS-1:0]   keep;
  logic [NKEYS-1:0]   done;
  logic [POS_W:0]     pos_plus;
  logic [VALUE_W+3:0] wide;
  logic               commit;
  logic               do_write;
  logic [VALUE_W-1:0] commit_val;

  // A final byte may only be taken when the result register can accept it.
  assign q_pop = q_nonempty && (!q_item.last || !out_valid || pop);
  assign pos_plus = {1'b0, pos} + (POS_W + 1)'(1);
  assign wide = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{VALUE_W{1'b0}}, q_item.digit};

  always_comb begin
    phase_next = phase;
    cand_next = cand;
    pos_next = pos;
    acc_next = acc;
    ovf_next = ovf;
    commit = 1'b0;
    keep = '0;
    done = '0;
    if (q_item.is_nl) begin
      phase_next = PH_BLANK;
      commit = (phase == PH_DIGITS);
    end else begin
      unique case (phase)
        PH_BLANK, PH_KEY: begin
          if (!(phase == PH_BLANK && q_item.is_blank)) begin
            for (int k = 0; k < NKEYS; k++) begin
              keep[k] = cand[k] && q_item.hits[k][pos];
              done[k] = keep[k] && (pos_plus == (POS_W + 1)'(KEY_LEN[k]));
            end
            pos_next = pos_plus[POS_W-1:0];
            if (keep == '0) begin
              phase_next = PH_IGNORE;
            end else if (done != '0) begin
              // Lowest completed key wins, as a one-hot select.
              cand_next = done & (~done + NKEYS'(1));
              phase_next = PH_GAP;
            end else begin
              cand_next = keep;
              phase_next = PH_KEY;
            end
          end
        end
        PH_GAP: begin
          if (q_item.is_digit) begin
            acc_next = {{(VALUE_W-4){1'b0}}, q_item.digit};
            ovf_next = 1'b0;
            phase_next = PH_DIGITS;
          end else if (!q_item.is_blank) begin
            phase_next = PH_IGNORE;
          end
        end
        PH_DIGITS: begin
          if (q_item.is_digit) begin
            if (!ovf) begin
              if (wide[VALUE_W+3:VALUE_W] != '0) begin
                ovf_next = 1'b1;
              end else begin
                acc_next = wide[VALUE_W-1:0];
              end
            end
          end else begin
            commit = 1'b1;
            phase_next = PH_IGNORE;
          end
        end
        PH_IGNORE: begin
        end
        default: begin
          phase_next = PH_IGNORE;
        end
      endcase
    end
    // The last byte closes an open digit run.
    if (q_item.last && phase_next == PH_DIGITS) begin
      commit = 1'b1;
    end
  end

  assign do_write = commit && !ovf_next;
  assign commit_val = (acc_next[VALUE_W-1:VALUE_W-SCALE_SHIFT] != '0) ? '1
                    : {acc_next[VALUE_W-SCALE_SHIFT-1:0], {SCALE_SHIFT{1'b0}}};
  assign any_ok_next = any_ok || do_write;

  always_comb begin
    for (int k = 0; k < NKEYS; k++) begin
      slots_next[k] = (do_write && cand_next[k]) ? commit_val : slots[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_BLANK;
      cand <= '1;
      pos <= '0;
      acc <= '0;
      ovf <= 1'b0;
      any_ok <= 1'b0;
      for (int k = 0; k < NKEYS; k++) begin
        slots[k] <= '0;
      end
    end else if (q_pop) begin
      if (q_item.last || q_item.is_nl) begin
        phase <= PH_BLANK;
        cand <= '1;
        pos <= '0;
        acc <= '0;
        ovf <= 1'b0;
      end else begin
        phase <= phase_next;
        cand <= cand_next;
        pos <= pos_next;
        acc <= acc_next;
        ovf <= ovf_next;
      end
      if (q_item.last) begin
        any_ok <= 1'b0;
        for (int k = 0; k < NKEYS; k++) begin
          slots[k] <= '0;
        end
      end else begin
        any_ok <= any_ok_next;
        for (int k = 0; k < NKEYS; k++) begin
          slots[k] <= slots_next[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && q_item.last) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.last) begin
      out_status <= !any_ok_next;
      for (int k = 0; k < NKEYS; k++) begin
        out_slots[k] <= slots_next[k];
      end
    end
  end

endmodule

// ===== hw/rtl/meminfo_key_value_parser_top.sv =====
// Top level of the meminfo key/value parser: classifier, queue and line parser.
// Throughput: one byte per cycle sustained; a held result stalls the parser only at a final
// byte, and the input stalls once the two-entry queue behind it fills.
// A final byte is first written into the queue register; the parser then takes it and loads
// the result register, and a held result can keep the byte waiting in the queue.
// Reset (synchronous, rst high) empties the queue and result register and clears all slots.
module meminfo_key_value_parser_top #(
  parameter int QueueDepth = mkvp_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [7:0]                   text_byte,
  input  logic                         final_byte,
  input  logic                         push,
  output logic                         full,
  output logic [mkvp_pkg::VALUE_W-1:0] total_bytes,
  output logic [mkvp_pkg::VALUE_W-1:0] free_bytes,
  output logic [mkvp_pkg::VALUE_W-1:0] available_bytes,
  output logic [mkvp_pkg::VALUE_W-1:0] buffer_bytes,
  output logic [mkvp_pkg::VALUE_W-1:0] cached_bytes,
  output logic [mkvp_pkg::VALUE_W-1:0] swap_total_bytes,
  output logic [mkvp_pkg::VALUE_W-1:0] swap_free_bytes,
  output logic                         status,
  output logic                         empty,
  input  logic                         pop
);
  import mkvp_pkg::*;

  logic               q_push;
  item_t              q_in;
  item_t              q_out;
  logic               q_nonempty;
  logic               q_pop;
  logic               out_valid;
  logic [VALUE_W-1:0] out_slots [NKEYS];

  mkvp_front u_front (
    .text_byte  (text_byte),
    .final_byte (final_byte),
    .push       (push),
    .q_full     (full),
    .q_push     (q_push),
    .q_item     (q_in)
  );

  mkvp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .item_in  (q_in),
    .full     (full),
    .pop      (q_pop),
    .item_out (q_out),
    .nonempty (q_nonempty)
  );

  mkvp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_item     (q_out),
    .q_nonempty (q_nonempty),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .pop        (pop),
    .out_slots  (out_slots),
    .out_status (status)
  );

  assign empty = !out_valid;
  assign total_bytes = out_slots[0];
  assign free_bytes = out_slots[1];
  assign available_bytes = out_slots[2];
  assign buffer_bytes = out_slots[3];
  assign cached_bytes = out_slots[4];
  assign swap_total_bytes = out_slots[5];
  assign swap_free_bytes = out_slots[6];

  a_reset_empties: assert property (@(posedge clk) rst |=> empty)
    else $error("result register not empty after reset");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_out.last) |-> (empty || pop))
    else $error("final byte parsed while an untaken result is held");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !(q_pop && q_out.last)) |=> empty)
    else $error("result still shown after its transfer");

  a_byte_queued: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> q_nonempty)
    else $error("transferred byte missing from the queue");

endmodule
